// File: src/scd_pkg.sv
// Package holding the shared types and constants of the stream chunk demultiplexer.
`timescale 1ns / 1ps
package scd_pkg;

	typedef enum logic [2:0] {
		KIND_FRAME_BYTE  = 3'd0,
		KIND_SOUND_BYTE  = 3'd1,
		KIND_VIDEO_BYTE  = 3'd2,
		KIND_AUDIO_BYTE  = 3'd3,
		KIND_FRAME_REC   = 3'd4,
		KIND_FILM_HDR    = 3'd5,
		KIND_SOUND_HDR   = 3'd6,
		KIND_STOPPED     = 3'd7
	} kind_t;

	localparam logic [31:0] TAG_FILM  = 32'h46494C4D;
	localparam logic [31:0] TAG_SNDS  = 32'h534E4453;
	localparam logic [31:0] TAG_MPVD  = 32'h4D505644;
	localparam logic [31:0] TAG_MPVC  = 32'h4D505643;
	localparam logic [31:0] TAG_MPAU  = 32'h4D504155;
	localparam logic [31:0] SUBT_FILM_HDR   = 32'h46484452;
	localparam logic [31:0] SUBT_SOUND_HDR  = 32'h53484452;
	localparam logic [31:0] SUBT_SAMPLES    = 32'h53534D50;
	localparam logic [31:0] SUBT_FRAME      = 32'h46524D45;
	localparam logic [31:0] SUBT_DROP_FRAME = 32'h4446524D;
	localparam logic [23:0] LOW24_FRM = 24'h46524D;
	localparam logic [15:0] SUB_FR    = 16'h4652;
	localparam logic [7:0]  CH_BRACKET = 8'h5D;
	localparam logic [7:0]  CH_ONE    = 8'h31;
	localparam logic [7:0]  CH_FOUR   = 8'h34;
	localparam logic [31:0] HDR_BYTES = 32'd20;

	typedef struct packed {
		logic             valid;
		kind_t            kind;
		logic [7:0]       data_byte;
		logic [5:0][31:0] words;
	} result_t;

endpackage

// File: src/scd_parser.sv
// Chunk parser: stream state, header decode and payload routing for one byte per step.
`timescale 1ns / 1ps
module scd_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       stream_byte,
	input  logic [31:0]      total_length,
	output scd_pkg::result_t res
);
	import scd_pkg::*;

	logic [31:0]      pos_q, off_q, asm_q, type_q, len_q, time_q, sub_q, plen_q, btp_q;
	logic [5:0][31:0] cw_q;
	logic             stopped_q;

	logic [31:0]      pos_n, off_n, asm_n, type_n, len_n, time_n, sub_n, plen_n, btp_n;
	logic [5:0][31:0] cw_n;
	logic             stopped_n;

	logic [31:0] w, q, start7, start19, want, dl, lim8, lim4, q20;
	logic [33:0] room;
	logic [32:0] extent;
	logic        end_hit, bad_len, early;

	assign w       = {asm_q[23:0], stream_byte};
	assign q       = off_q - HDR_BYTES;
	assign q20     = q - 32'd20;
	assign start7  = pos_q - 32'd7;
	assign start19 = pos_q - 32'd19;
	assign end_hit = ({1'b0, pos_q} + 33'd20) > {1'b0, total_length};
	assign bad_len = ({2'b0, start7} + {2'b0, w}) > ({2'b0, total_length} + 34'd3);
	assign room    = {2'b0, total_length} - {2'b0, start19} - 34'd20;
	assign want    = len_q - HDR_BYTES;
	assign extent  = ({1'b0, len_q} + 33'd3) & ~33'd3;
	assign dl      = (w > 32'd8) ? (w - 32'd8) : 32'd0;
	assign lim8    = plen_q - 32'd8;
	assign lim4    = plen_q - 32'd4;

	always_comb begin
		pos_n = pos_q; off_n = off_q; asm_n = asm_q; type_n = type_q; len_n = len_q;
		time_n = time_q; sub_n = sub_q; plen_n = plen_q; btp_n = btp_q; cw_n = cw_q;
		stopped_n = stopped_q;
		early = 1'b0;
		res = '0;
		if (step && !stopped_q) begin
			if (off_q == 32'd0 && end_hit) begin
				stopped_n = 1'b1;
				res.valid = 1'b1;
				res.kind  = KIND_STOPPED;
			end else begin
				asm_n = w;
				if (off_q < HDR_BYTES) begin
					if (off_q == 32'd3) begin
						type_n = w;
					end else if (off_q == 32'd7) begin
						len_n = w;
						if (w < HDR_BYTES || bad_len) begin
							stopped_n = 1'b1;
							res.valid = 1'b1;
							res.kind  = KIND_STOPPED;
							early     = 1'b1;
						end
					end else if (off_q == 32'd11) begin
						time_n = w;
					end else if (off_q == 32'd19) begin
						sub_n = w;
						// A negative room means the stream ends before the chunk payload begins.
						if (room[33] || ({2'b0, want} < room))
							plen_n = want;
						else
							plen_n = room[31:0];
						btp_n = extent[31:0] - HDR_BYTES;
					end
				end else begin
					btp_n = btp_q - 32'd1;
					if (q < plen_q) begin
						priority if (type_q == TAG_FILM && sub_q == SUBT_FILM_HDR
							&& plen_q >= 32'd24) begin
							if (q < 32'd24 && q[1:0] == 2'd3)
								cw_n[q[4:2]] = w;
							if (q == 32'd23) begin
								res.valid = 1'b1;
								res.kind  = KIND_FILM_HDR;
								res.words = {32'd0, w, cw_q[4], cw_q[3], cw_q[2], cw_q[1]};
							end
						end else if (type_q == TAG_FILM
							&& (sub_q == SUBT_FRAME || sub_q == SUBT_DROP_FRAME)
							&& plen_q >= 32'd8) begin
							if (q == 32'd3) begin
								cw_n[0] = w;
							end else if (q == 32'd7) begin
								cw_n[1] = w;
								cw_n[2] = (dl < lim8) ? dl : lim8;
								res.valid = 1'b1;
								res.kind  = KIND_FRAME_REC;
								res.words = {32'd0, 32'd0, 32'd0, cw_n[2], cw_q[0], time_q};
							end else if (q >= 32'd8 && (q - 32'd8) < cw_q[2]) begin
								res.valid     = 1'b1;
								res.kind      = KIND_FRAME_BYTE;
								res.data_byte = stream_byte;
							end
						end else if (type_q == TAG_SNDS && sub_q == SUBT_SOUND_HDR
							&& plen_q >= 32'd44) begin
							if (q >= 32'd20 && q < 32'd44 && q[1:0] == 2'd3)
								cw_n[q20[4:2]] = w;
							if (q == 32'd43) begin
								res.valid = 1'b1;
								res.kind  = KIND_SOUND_HDR;
								res.words = {w, cw_q[4], cw_q[3], cw_q[2], cw_q[1], cw_q[0]};
							end
						end else if (type_q == TAG_SNDS && sub_q == SUBT_SAMPLES
							&& plen_q >= 32'd4) begin
							if (q == 32'd3) begin
								cw_n[0] = (w < lim4) ? w : lim4;
							end else if (q >= 32'd4 && (q - 32'd4) < cw_q[0]) begin
								res.valid     = 1'b1;
								res.kind      = KIND_SOUND_BYTE;
								res.data_byte = stream_byte;
							end
						end else if ((type_q == TAG_MPVD || type_q == TAG_MPVC)
							&& sub_q[31:16] == SUB_FR && plen_q > 32'd4) begin
							// The 4-byte prefix is kept only for subtypes ending in a bracket.
							if (sub_q[7:0] == CH_BRACKET || q >= 32'd4) begin
								res.valid     = 1'b1;
								res.kind      = KIND_VIDEO_BYTE;
								res.data_byte = stream_byte;
							end
						end else if (type_q == TAG_MPAU && plen_q > 32'd0) begin
							if (sub_q[31:24] >= CH_ONE && sub_q[31:24] <= CH_FOUR
								&& sub_q[23:0] == LOW24_FRM) begin
								res.valid     = 1'b1;
								res.kind      = KIND_AUDIO_BYTE;
								res.data_byte = stream_byte;
							end
						end else begin
							res.valid = 1'b0;
						end
					end
				end
				if (!early) begin
					if (pos_q != 32'hFFFFFFFF)
						pos_n = pos_q + 32'd1;
					if (off_q >= 32'd19 && btp_n == 32'd0)
						off_n = 32'd0;
					else
						off_n = off_q + 32'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; off_q <= '0; asm_q <= '0; type_q <= '0; len_q <= '0;
			time_q <= '0; sub_q <= '0; plen_q <= '0; btp_q <= '0; cw_q <= '0;
			stopped_q <= 1'b0;
		end else begin
			pos_q <= pos_n; off_q <= off_n; asm_q <= asm_n; type_q <= type_n;
			len_q <= len_n; time_q <= time_n; sub_q <= sub_n; plen_q <= plen_n;
			btp_q <= btp_n; cw_q <= cw_n; stopped_q <= stopped_n;
		end
	end

`ifndef SYNTHESIS
	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |=> stopped_q) else $error("stop flag cleared without reset");
	a_stop_sets: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.kind == KIND_STOPPED) |=> stopped_q)
		else $error("stop result without stop flag");
	a_quiet_after_stop: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |-> !res.valid) else $error("result after the chain stopped");
`endif

endmodule

// File: src/stream_chunk_demultiplexer_unit.sv
// Top level of the stream chunk demultiplexer: byte input register, parser, result register.
//
//  channel  handshake             payload
//  -------  --------------------  ----------------------------------------------
//  in       in_valid / in_ready   stream_byte
//  out      out_valid / out_ready kind, data_byte, word_first .. word_sixth
//  cfg      cfg_valid / cfg_ready cfg_data (total_length)
//
// One byte is taken per cycle unless a held result stalls it; out_valid is registered
// behind the input register. The rate is set by the parser, one byte per step.
// Reset clears all parser state and the configured stream length.
// A held result stalls the byte in the input register; input stops only when both
// registers are full and the held result is not taken in that cycle.
`timescale 1ns / 1ps
module stream_chunk_demultiplexer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  stream_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [7:0]  data_byte,
	output logic [31:0] word_first,
	output logic [31:0] word_second,
	output logic [31:0] word_third,
	output logic [31:0] word_fourth,
	output logic [31:0] word_fifth,
	output logic [31:0] word_sixth,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);
	import scd_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        out_valid_s2;
	result_t     res, res_s2;
	logic [31:0] total_q;
	logic        out_free, step;

	assign out_free  = !out_valid_s2 || out_ready;
	assign step      = valid_s1 && out_free;
	assign in_ready  = !valid_s1 || out_free;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (cfg_valid) begin
			total_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			byte_s1 <= stream_byte;
	end

	scd_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.stream_byte (byte_s1),
		.total_length(total_q),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (step && res.valid) begin
			out_valid_s2 <= 1'b1;
		end else if (out_ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.valid)
			res_s2 <= res;
	end

	assign out_valid   = out_valid_s2;
	assign kind        = res_s2.kind;
	assign data_byte   = res_s2.data_byte;
	assign word_first  = res_s2.words[0];
	assign word_second = res_s2.words[1];
	assign word_third  = res_s2.words[2];
	assign word_fourth = res_s2.words[3];
	assign word_fifth  = res_s2.words[4];
	assign word_sixth  = res_s2.words[5];

`ifndef SYNTHESIS
	a_step_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_s2 && !out_ready) |-> !step) else $error("step while result held");
	a_block_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_s2)) else $error("input blocked while not full");
	a_byte_consumed: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !(in_valid && in_ready)) |=> !valid_s1)
		else $error("request kept after its step");
`endif

endmodule

// File: tb/sv/tb_stream_chunk_demultiplexer_unit.sv
// Testbench for the stream chunk demultiplexer: directed and random chunk chains, self-checked.
`timescale 1ns / 1ps
module tb_stream_chunk_demultiplexer_unit;
	import scd_pkg::*;

	typedef struct packed {
		kind_t            kind;
		logic [7:0]       data;
		logic [5:0][31:0] words;
	} outcome_t;

	// Expectation codes of the directed table; 0 to 7 mean that kind with the row's byte.
	localparam logic [3:0] EXP_NONE = 4'd8;
	localparam logic [3:0] EXP_PRED = 4'd9;
	localparam int DIR_ROWS = 24;
	localparam logic [31:0] LEN_MAX = 32'hFFFFFFFF;

	// One audio chunk of subtype 1FRM with a single payload byte and three pad bytes.
	localparam logic [7:0] DIR_BYTES [DIR_ROWS] = '{
		8'h4D, 8'h50, 8'h41, 8'h55, 8'h00, 8'h00, 8'h00, 8'h15,
		8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h31, 8'h46, 8'h52, 8'h4D, 8'hFF, 8'h00, 8'hA5, 8'h5A
	};
	localparam logic [3:0] DIR_EXPECT [DIR_ROWS] = '{
		EXP_NONE, EXP_NONE, EXP_NONE, EXP_NONE, EXP_NONE, EXP_NONE, EXP_NONE, EXP_NONE,
		EXP_NONE, EXP_NONE, EXP_NONE, EXP_NONE, EXP_NONE, EXP_NONE, EXP_NONE, EXP_NONE,
		EXP_NONE, EXP_NONE, EXP_NONE, EXP_NONE, 4'(KIND_AUDIO_BYTE), EXP_PRED, EXP_PRED,
		EXP_PRED
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  stream_byte;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  kind;
	logic [7:0]  data_byte;
	logic [31:0] word_first, word_second, word_third, word_fourth, word_fifth, word_sixth;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;

	stream_chunk_demultiplexer_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .stream_byte(stream_byte),
		.out_valid(out_valid), .out_ready(out_ready), .kind(kind), .data_byte(data_byte),
		.word_first(word_first), .word_second(word_second), .word_third(word_third),
		.word_fourth(word_fourth), .word_fifth(word_fifth), .word_sixth(word_sixth),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// Parser copy used to work out the expected records and bytes.
	logic [31:0] total_len, pos, offs, shift_w, ctype, clen, ctime, csub, plen, remain;
	logic [31:0] cap [6];
	bit          halted;

	outcome_t    pending_q [$];
	logic [7:0]  chunk_bytes [$];
	int unsigned errors;
	int unsigned sent;
	bit          calm;
	int unsigned stall_left;

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		stream_byte = 8'h00;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 32'd0;
	end

	always #5 clk = ~clk;

	initial begin
		#5ms;
		$display("TEST FAILED");
		$finish;
	end

	task automatic report(input string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		errors++;
	endtask

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [31:0] min32(input logic [31:0] a, input logic [31:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic bit payload_out(input logic [31:0] q, input logic [7:0] b,
			inout outcome_t r);
		logic [31:0] w;
		logic [31:0] dl;
		logic [31:0] skip;
		w = shift_w;
		if (q >= plen)
			return 0;
		if (ctype == TAG_FILM && csub == SUBT_FILM_HDR && plen >= 24) begin
			if (q < 24 && q[1:0] == 2'd3)
				cap[q >> 2] = w;
			if (q == 23) begin
				r.kind = KIND_FILM_HDR;
				r.words = {32'd0, cap[5], cap[4], cap[3], cap[2], cap[1]};
				return 1;
			end
			return 0;
		end
		if (ctype == TAG_FILM && (csub == SUBT_FRAME || csub == SUBT_DROP_FRAME)
				&& plen >= 8) begin
			if (q == 3) begin
				cap[0] = w;
			end else if (q == 7) begin
				dl = (w > 8) ? w - 8 : 32'd0;
				cap[1] = w;
				cap[2] = min32(dl, plen - 8);
				r.kind = KIND_FRAME_REC;
				r.words = {32'd0, 32'd0, 32'd0, cap[2], cap[0], ctime};
				return 1;
			end else if (q >= 8 && q - 8 < cap[2]) begin
				r.kind = KIND_FRAME_BYTE;
				r.data = b;
				return 1;
			end
			return 0;
		end
		if (ctype == TAG_SNDS && csub == SUBT_SOUND_HDR && plen >= 44) begin
			if (q >= 20 && q < 44 && q[1:0] == 2'd3)
				cap[(q - 20) >> 2] = w;
			if (q == 43) begin
				r.kind = KIND_SOUND_HDR;
				r.words = {cap[5], cap[4], cap[3], cap[2], cap[1], cap[0]};
				return 1;
			end
			return 0;
		end
		if (ctype == TAG_SNDS && csub == SUBT_SAMPLES && plen >= 4) begin
			if (q == 3) begin
				cap[0] = min32(w, plen - 4);
			end else if (q >= 4 && q - 4 < cap[0]) begin
				r.kind = KIND_SOUND_BYTE;
				r.data = b;
				return 1;
			end
			return 0;
		end
		if ((ctype == TAG_MPVD || ctype == TAG_MPVC) && csub[31:16] == SUB_FR && plen > 4) begin
			skip = (csub[7:0] != CH_BRACKET) ? 32'd4 : 32'd0;
			if (q >= skip) begin
				r.kind = KIND_VIDEO_BYTE;
				r.data = b;
				return 1;
			end
			return 0;
		end
		if (ctype == TAG_MPAU && plen > 0 && csub[31:24] >= CH_ONE && csub[31:24] <= CH_FOUR
				&& csub[23:0] == LOW24_FRM) begin
			r.kind = KIND_AUDIO_BYTE;
			r.data = b;
			return 1;
		end
		return 0;
	endfunction

	function automatic bit demux_step(input logic [7:0] b, output outcome_t r);
		logic [31:0] off;
		logic [63:0] start, room, want, extent;
		bit hit;
		off = offs;
		hit = 0;
		r = '0;
		if (halted)
			return 0;
		if (off == 0 && {32'd0, pos} + 64'd20 > {32'd0, total_len}) begin
			halted = 1;
			r.kind = KIND_STOPPED;
			return 1;
		end
		shift_w = {shift_w[23:0], b};
		if (off < 20) begin
			case (off)
				3: ctype = shift_w;
				7: begin
					start = {32'd0, pos - 32'd7};
					clen = shift_w;
					if (clen < 20 || start + {32'd0, clen} > {32'd0, total_len} + 64'd3) begin
						halted = 1;
						r.kind = KIND_STOPPED;
						return 1;
					end
				end
				11: ctime = shift_w;
				19: begin
					start = {32'd0, pos - 32'd19};
					room = {32'd0, total_len} - start - 64'd20;
					want = {32'd0, clen} - 64'd20;
					extent = ({32'd0, clen} + 64'd3) & ~64'd3;
					csub = shift_w;
					plen = (want < room) ? want[31:0] : room[31:0];
					remain = extent[31:0] - 32'd20;
				end
				default: ;
			endcase
		end else begin
			hit = payload_out(off - 20, b, r);
			remain = remain - 1;
		end
		if (pos != LEN_MAX)
			pos = pos + 1;
		offs = (off >= 19 && remain == 0) ? 32'd0 : off + 1;
		return hit;
	endfunction

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task automatic send_byte(input logic [7:0] b, input logic [3:0] expect_code);
		int unsigned gap;
		outcome_t r;
		bit hit;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		stream_byte <= b;
		do
			@(posedge clk);
		while (!in_ready);
		hit = demux_step(b, r);
		if (expect_code == EXP_PRED) begin
			if (hit)
				pending_q.insert(pending_q.size(), r);
		end else if (expect_code != EXP_NONE) begin
			r = '0;
			r.kind = kind_t'(expect_code[2:0]);
			r.data = b;
			pending_q.insert(pending_q.size(), r);
		end
		sent++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_q.size() != 0)
			@(negedge clk);
		// A byte that yields nothing may still be in flight behind the last result.
		repeat (8) @(negedge clk);
	endtask

	task automatic write_length(input logic [31:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		total_len = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_chunk();
		calm = ($urandom_range(0, 3) == 0);
		while (chunk_bytes.size() != 0)
			send_byte(chunk_bytes.pop_front(), EXP_PRED);
	endtask

	function automatic void put_word(input logic [31:0] w);
		for (int i = 3; i >= 0; i--)
			chunk_bytes.insert(chunk_bytes.size(), w[i*8 +: 8]);
	endfunction

	// Builds one chunk into chunk_bytes and returns its payload length.
	function automatic int unsigned build_chunk(input logic [31:0] size_override,
			input bit use_override);
		logic [31:0] typ, sub, w;
		logic [7:0] pl [$];
		int unsigned p, sel;
		bit shortp, coin;
		sel = $urandom_range(0, 6);
		shortp = ($urandom_range(0, 4) == 0);
		coin = $urandom_range(0, 1);
		typ = $urandom;
		sub = $urandom;
		p = $urandom_range(0, 30);
		case (sel)
			0: begin
				typ = TAG_FILM; sub = SUBT_FILM_HDR;
				p = shortp ? $urandom_range(0, 23) : $urandom_range(24, 40);
			end
			1: begin
				typ = TAG_FILM; sub = coin ? SUBT_FRAME : SUBT_DROP_FRAME;
				p = shortp ? $urandom_range(0, 7) : $urandom_range(8, 60);
			end
			2: begin
				typ = TAG_SNDS; sub = SUBT_SOUND_HDR;
				p = shortp ? $urandom_range(0, 43) : $urandom_range(44, 60);
			end
			3: begin
				typ = TAG_SNDS; sub = SUBT_SAMPLES;
				p = shortp ? $urandom_range(0, 3) : $urandom_range(4, 50);
			end
			4: begin
				typ = coin ? TAG_MPVD : TAG_MPVC;
				sub = {SUB_FR, 8'($urandom), $urandom_range(0, 1) ? CH_BRACKET : 8'($urandom)};
				if (shortp)
					sub[31:16] = 16'($urandom);
				p = $urandom_range(0, 40);
			end
			5: begin
				typ = TAG_MPAU;
				sub = {8'(CH_ONE - 8'd1 + 8'($urandom_range(0, 5))), LOW24_FRM};
				if (shortp)
					sub[23:0] = 24'($urandom);
				p = $urandom_range(0, 40);
			end
			default: ;
		endcase
		if ($urandom_range(0, 24) == 0)
			p = $urandom_range(100, 180);
		for (int i = 0; i < p; i++)
			pl.insert(pl.size(), 8'($urandom));
		if (sel == 1 && p >= 8) begin
			case ($urandom_range(0, 3))
				0: w = p - 8 + $urandom_range(0, 12);
				1: w = $urandom_range(0, 8);
				2: w = $urandom;
				default: w = p + $urandom_range(0, 4);
			endcase
			for (int i = 0; i < 4; i++)
				pl[4 + i] = w[(3 - i)*8 +: 8];
		end
		if (sel == 3 && p >= 4) begin
			case ($urandom_range(0, 2))
				0: w = $urandom_range(0, p);
				1: w = $urandom;
				default: w = p - 4;
			endcase
			for (int i = 0; i < 4; i++)
				pl[i] = w[(3 - i)*8 +: 8];
		end
		put_word(typ);
		put_word(use_override ? size_override : 32'(p + 20));
		put_word($urandom);
		put_word($urandom);
		put_word(sub);
		foreach (pl[i])
			chunk_bytes.insert(chunk_bytes.size(), pl[i]);
		while ((chunk_bytes.size() % 4) != 0)
			chunk_bytes.insert(chunk_bytes.size(), 8'($urandom));
		return p;
	endfunction

	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else begin
			out_ready <= 1'b1;
			if (!calm)
				stall_left = pick_gap();
		end
	end

	always @(posedge clk) begin
		outcome_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_q.size() == 0) begin
				report($sformatf("unexpected result of kind %0d", kind));
			end else begin
				e = pending_q.pop_front();
				if (kind !== e.kind)
					report($sformatf("kind %0d, wanted %0d", kind, e.kind));
				if (data_byte !== e.data)
					report($sformatf("data_byte %h, wanted %h", data_byte, e.data));
				if (word_first !== e.words[0])
					report($sformatf("word_first %h, wanted %h", word_first, e.words[0]));
				if (word_second !== e.words[1])
					report($sformatf("word_second %h, wanted %h", word_second, e.words[1]));
				if (word_third !== e.words[2])
					report($sformatf("word_third %h, wanted %h", word_third, e.words[2]));
				if (word_fourth !== e.words[3])
					report($sformatf("word_fourth %h, wanted %h", word_fourth, e.words[3]));
				if (word_fifth !== e.words[4])
					report($sformatf("word_fifth %h, wanted %h", word_fifth, e.words[4]));
				if (word_sixth !== e.words[5])
					report($sformatf("word_sixth %h, wanted %h", word_sixth, e.words[5]));
			end
		end
	end

	initial begin
		int unsigned p, r, ending;
		errors = 0;
		sent = 0;
		calm = 0;
		stall_left = 0;
		total_len = 0; pos = 0; offs = 0; shift_w = 0; ctype = 0; clen = 0;
		ctime = 0; csub = 0; plen = 0; remain = 0; halted = 0;
		foreach (cap[i])
			cap[i] = 0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		write_length(LEN_MAX);
		for (int i = 0; i < DIR_ROWS; i++)
			send_byte(DIR_BYTES[i], DIR_EXPECT[i]);

		while (sent < 620) begin
			p = build_chunk(32'd0, 0);
			if (p >= 3 && $urandom_range(0, 5) == 0) begin
				// Cut the stream inside this payload, then open it up again.
				r = $urandom_range(1, 3);
				write_length(pos + 20 + p - r);
				send_chunk();
				write_length(LEN_MAX - $urandom_range(0, 1));
			end else begin
				send_chunk();
			end
		end

		ending = $urandom_range(0, 2);
		if (ending == 0) begin
			write_length(pos + $urandom_range(0, 19));
			send_byte(8'($urandom), EXP_PRED);
		end else begin
			if (ending == 2)
				write_length(pos + 100);
			void'(build_chunk((ending == 1) ? 32'($urandom_range(0, 19))
				: 32'($urandom_range(104, 200)), 1));
			send_chunk();
		end
		for (int i = 0; i < 10; i++)
			send_byte(8'($urandom), EXP_PRED);
		write_length(32'd0);
		for (int i = 0; i < 5; i++)
			send_byte(8'($urandom), EXP_PRED);

		wait_idle();
		repeat (10) @(posedge clk);
		if (errors == 0 && pending_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: sim.f
src/scd_pkg.sv
src/scd_parser.sv
src/stream_chunk_demultiplexer_unit.sv
tb/sv/tb_stream_chunk_demultiplexer_unit.sv
